@@ hw/rtl/ale_pkg.sv @@
// Shared types, codes and field widths for the array list engine.
package ale_pkg;

  localparam int unsigned DefCapacity = 8;

  localparam int unsigned ActW   = 4;
  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned OffW   = 8;
  localparam int unsigned StatW  = 3;
  localparam int unsigned FidxW  = 3;
  localparam int unsigned LenW   = 4;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [ActW-1:0] {
    ACT_INS_FRONT = 4'd0,
    ACT_INS_BACK  = 4'd1,
    ACT_INS_AT    = 4'd2,
    ACT_DEL_FRONT = 4'd3,
    ACT_DEL_BACK  = 4'd4,
    ACT_DEL_AT    = 4'd5,
    ACT_SEARCH    = 4'd6,
    ACT_LIST_ALL  = 4'd7,
    ACT_ROTATE    = 4'd8
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_UP,
    S_PUT,
    S_DREAD,
    S_DOWN,
    S_SRCH,
    S_LREAD,
    S_LOUT,
    S_RMOD,
    S_RCOPY,
    S_RBACK,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [WordW-1:0] value;
    logic [WordW-1:0] key;
    logic [PosW-1:0]  position;
    logic [OffW-1:0]  offset;
  } item_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [WordW-1:0] word;
    logic [FidxW-1:0] found_index;
    logic [LenW-1:0]  length;
    logic             last;
  } res_t;

endpackage

@@ hw/rtl/array_list_engine.sv @@
// Top level of the array list engine: stream ports, field packing and output register.
// An item's run time is set by the walk over the entry store (one read port, one write
// port): inserts and deletes step over each moved entry, search over each entry up to a hit.
// Rotate runs the remainder unit, then a copy pass and a copy-back pass; list_all reads
// and outputs each entry. One item is in work at a time. Reset empties the list at once.
module array_list_engine #(
  parameter int unsigned CAPACITY = ale_pkg::DefCapacity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // action, value, key, position, offset
  input  logic [ale_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status, word, found_index, length, zero fill
  output logic [ale_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast
);

  ale_pkg::item_t item;
  ale_pkg::res_t  res, res_q;
  logic           res_valid, res_ready, out_valid_q;

  assign item.action   = s_axis_tdata[3:0];
  assign item.value    = s_axis_tdata[35:4];
  assign item.key      = s_axis_tdata[67:36];
  assign item.position = s_axis_tdata[71:68];
  assign item.offset   = s_axis_tdata[79:72];

  ale_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) res_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {6'd0, res_q.length, res_q.found_index, res_q.word, res_q.status};

endmodule

@@ hw/rtl/ale_mod.sv @@
// Bit-serial remainder unit that reduces the rotate offset modulo the list length.
module ale_mod #(
  parameter int unsigned CAPACITY = ale_pkg::DefCapacity
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [ale_pkg::OffW-1:0]             dividend_i,
  input  logic [$clog2(CAPACITY+1)-1:0]        divisor_i,
  output logic                                 done_o,
  output logic [$clog2(CAPACITY+1)-1:0]        rem_o
);

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned StepW = $clog2(ale_pkg::OffW);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [StepW-1:0]         step_q, step_d;
  logic [ale_pkg::OffW-1:0] dvd_q, dvd_d;
  logic [CW-1:0]            rem_q, rem_d;
  logic [CW:0]              trial;
  logic [CW:0]              dsor;

  assign trial = {rem_q, dvd_q[ale_pkg::OffW-1]};
  assign dsor  = {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= dsor) begin
        rem_d = CW'(trial - dsor);
      end else begin
        rem_d = CW'(trial);
      end
      dvd_d  = dvd_q << 1;
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(ale_pkg::OffW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ hw/rtl/ale_ctrl.sv @@
// Sequencer with the entry store and rotate buffer that carries out one action per item.
module ale_ctrl #(
  parameter int unsigned CAPACITY = ale_pkg::DefCapacity
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ale_pkg::item_t in_item_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output ale_pkg::res_t  res_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CmpW = (CW > ale_pkg::PosW) ? CW : ale_pkg::PosW;
  localparam int unsigned WW   = ale_pkg::WordW;

  ale_pkg::state_e  state_q, state_d;
  ale_pkg::action_e act_q;
  ale_pkg::status_e status_q, status_d;

  logic [WW-1:0]   value_q, key_q, word_q, word_d;
  logic [ale_pkg::PosW-1:0] pos_q;
  logic [ale_pkg::OffW-1:0] off_q;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   p_q, p_d;
  logic [AW-1:0]   j_q, j_d;
  logic [AW-1:0]   wa_q, wa_d;
  logic [AW-1:0]   fidx_q, fidx_d;
  logic            pend_q, pend_d;

  logic [WW-1:0]   ent_mem [CAPACITY];
  logic [WW-1:0]   tmp_mem [CAPACITY];
  logic [WW-1:0]   ent_rd_q, tmp_rd_q;
  logic            ent_re, ent_we, tmp_re, tmp_we;
  logic [AW-1:0]   ent_ra, ent_wa, tmp_ra, tmp_wa;
  logic [WW-1:0]   ent_wd;

  logic            accept;
  logic            mod_start, mod_done;
  logic [CW-1:0]   mod_rem;
  logic [CmpW-1:0] cnt_ext, ins_p, del_p;
  logic [CW:0]     idx_inc;
  logic            idx_lt_cnt, at_full, cnt_zero, list_last, srch_hit;
  logic [CW-1:0]   j_inc;

  assign accept     = in_valid_i && (state_q == ale_pkg::S_IDLE);
  assign in_ready_o = (state_q == ale_pkg::S_IDLE);

  assign cnt_ext    = CmpW'(count_q);
  assign idx_inc    = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_lt_cnt = idx_q < count_q;
  assign at_full    = count_q == CW'(CAPACITY);
  assign cnt_zero   = count_q == '0;
  assign list_last  = idx_inc == {1'b0, count_q};
  assign srch_hit   = pend_q && (ent_rd_q == key_q);
  assign j_inc      = CW'(j_q) + CW'(1);

  always_comb begin
    case (act_q)
      ale_pkg::ACT_INS_FRONT: ins_p = '0;
      ale_pkg::ACT_INS_BACK:  ins_p = cnt_ext;
      default:                ins_p = CmpW'(pos_q);
    endcase
    case (act_q)
      ale_pkg::ACT_DEL_FRONT: del_p = '0;
      ale_pkg::ACT_DEL_BACK:  del_p = cnt_ext - CmpW'(1);
      default:                del_p = CmpW'(pos_q);
    endcase
  end

  ale_mod #(
    .CAPACITY(CAPACITY)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (off_q),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ale_pkg::S_IDLE: begin
        if (accept) state_d = ale_pkg::S_START;
      end
      ale_pkg::S_START: begin
        case (act_q)
          ale_pkg::ACT_INS_FRONT, ale_pkg::ACT_INS_BACK, ale_pkg::ACT_INS_AT: begin
            if (ins_p > cnt_ext || at_full) state_d = ale_pkg::S_RESULT;
            else state_d = ale_pkg::S_UP;
          end
          ale_pkg::ACT_DEL_FRONT, ale_pkg::ACT_DEL_BACK, ale_pkg::ACT_DEL_AT: begin
            if (cnt_zero || del_p >= cnt_ext) state_d = ale_pkg::S_RESULT;
            else state_d = ale_pkg::S_DREAD;
          end
          ale_pkg::ACT_SEARCH: state_d = ale_pkg::S_SRCH;
          ale_pkg::ACT_LIST_ALL: begin
            state_d = cnt_zero ? ale_pkg::S_RESULT : ale_pkg::S_LREAD;
          end
          ale_pkg::ACT_ROTATE: begin
            state_d = cnt_zero ? ale_pkg::S_RESULT : ale_pkg::S_RMOD;
          end
          default: state_d = ale_pkg::S_RESULT;
        endcase
      end
      ale_pkg::S_UP: begin
        if (!(idx_q > p_q)) state_d = ale_pkg::S_PUT;
      end
      ale_pkg::S_PUT:   state_d = ale_pkg::S_RESULT;
      ale_pkg::S_DREAD: state_d = ale_pkg::S_DOWN;
      ale_pkg::S_DOWN: begin
        if (!(idx_inc < {1'b0, count_q})) state_d = ale_pkg::S_RESULT;
      end
      ale_pkg::S_SRCH: begin
        if (srch_hit || !idx_lt_cnt) state_d = ale_pkg::S_RESULT;
      end
      ale_pkg::S_LREAD: state_d = ale_pkg::S_LOUT;
      ale_pkg::S_LOUT: begin
        if (res_ready_i) state_d = list_last ? ale_pkg::S_IDLE : ale_pkg::S_LREAD;
      end
      ale_pkg::S_RMOD: begin
        if (mod_done) state_d = ale_pkg::S_RCOPY;
      end
      ale_pkg::S_RCOPY: begin
        if (!idx_lt_cnt) state_d = ale_pkg::S_RBACK;
      end
      ale_pkg::S_RBACK: begin
        if (!idx_lt_cnt) state_d = ale_pkg::S_RESULT;
      end
      ale_pkg::S_RESULT: begin
        if (res_ready_i) state_d = ale_pkg::S_IDLE;
      end
      default: state_d = ale_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    status_d  = status_q;
    word_d    = word_q;
    fidx_d    = fidx_q;
    count_d   = count_q;
    idx_d     = idx_q;
    p_d       = p_q;
    j_d       = j_q;
    wa_d      = wa_q;
    pend_d    = pend_q;
    mod_start = 1'b0;
    ent_re    = 1'b0;
    ent_ra    = idx_q[AW-1:0];
    ent_we    = 1'b0;
    ent_wa    = wa_q;
    ent_wd    = ent_rd_q;
    tmp_re    = 1'b0;
    tmp_ra    = idx_q[AW-1:0];
    tmp_we    = 1'b0;
    tmp_wa    = wa_q;
    res_valid_o = 1'b0;
    res_o.status      = status_q;
    res_o.word        = word_q;
    res_o.found_index = ale_pkg::FidxW'(fidx_q);
    res_o.length      = ale_pkg::LenW'(count_q);
    res_o.last        = 1'b1;
    case (state_q)
      ale_pkg::S_START: begin
        status_d = ale_pkg::ST_OK;
        word_d   = '0;
        fidx_d   = '0;
        pend_d   = 1'b0;
        idx_d    = '0;
        case (act_q)
          ale_pkg::ACT_INS_FRONT, ale_pkg::ACT_INS_BACK, ale_pkg::ACT_INS_AT: begin
            if (ins_p > cnt_ext) status_d = ale_pkg::ST_BADPOS;
            else if (at_full) status_d = ale_pkg::ST_FULL;
            idx_d = count_q;
            p_d   = CW'(ins_p);
          end
          ale_pkg::ACT_DEL_FRONT, ale_pkg::ACT_DEL_BACK, ale_pkg::ACT_DEL_AT: begin
            if (cnt_zero) status_d = ale_pkg::ST_EMPTY;
            else if (del_p >= cnt_ext) status_d = ale_pkg::ST_BADPOS;
            ent_re = 1'b1;
            ent_ra = AW'(del_p);
            idx_d  = CW'(del_p);
          end
          ale_pkg::ACT_LIST_ALL, ale_pkg::ACT_ROTATE: begin
            if (cnt_zero) status_d = ale_pkg::ST_EMPTY;
            mod_start = (act_q == ale_pkg::ACT_ROTATE) && !cnt_zero;
          end
          default: ;
        endcase
      end
      ale_pkg::S_UP: begin
        ent_we = pend_q;
        if (idx_q > p_q) begin
          ent_re = 1'b1;
          ent_ra = AW'(idx_q - CW'(1));
          wa_d   = idx_q[AW-1:0];
          pend_d = 1'b1;
          idx_d  = idx_q - CW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end
      ale_pkg::S_PUT: begin
        ent_we  = 1'b1;
        ent_wa  = p_q[AW-1:0];
        ent_wd  = value_q;
        count_d = count_q + CW'(1);
      end
      ale_pkg::S_DREAD: begin
        word_d = ent_rd_q;
        pend_d = 1'b0;
      end
      ale_pkg::S_DOWN: begin
        ent_we = pend_q;
        if (idx_inc < {1'b0, count_q}) begin
          ent_re = 1'b1;
          ent_ra = AW'(idx_inc);
          wa_d   = idx_q[AW-1:0];
          pend_d = 1'b1;
          idx_d  = CW'(idx_inc);
        end else begin
          pend_d  = 1'b0;
          count_d = count_q - CW'(1);
        end
      end
      ale_pkg::S_SRCH: begin
        if (srch_hit) begin
          fidx_d   = wa_q;
          status_d = ale_pkg::ST_OK;
        end else if (idx_lt_cnt) begin
          ent_re = 1'b1;
          wa_d   = idx_q[AW-1:0];
          pend_d = 1'b1;
          idx_d  = CW'(idx_inc);
        end else begin
          status_d = ale_pkg::ST_NOTFOUND;
        end
      end
      ale_pkg::S_LREAD: begin
        ent_re = 1'b1;
      end
      ale_pkg::S_LOUT: begin
        res_valid_o  = 1'b1;
        res_o.status = ale_pkg::ST_OK;
        res_o.word   = ent_rd_q;
        res_o.found_index = '0;
        res_o.last   = list_last;
        if (res_ready_i) idx_d = CW'(idx_inc);
      end
      ale_pkg::S_RMOD: begin
        j_d    = mod_rem[AW-1:0];
        pend_d = 1'b0;
        idx_d  = '0;
      end
      ale_pkg::S_RCOPY: begin
        tmp_we = pend_q;
        if (idx_lt_cnt) begin
          ent_re = 1'b1;
          wa_d   = j_q;
          pend_d = 1'b1;
          idx_d  = CW'(idx_inc);
          j_d    = (j_inc == count_q) ? '0 : j_inc[AW-1:0];
        end else begin
          pend_d = 1'b0;
          idx_d  = '0;
        end
      end
      ale_pkg::S_RBACK: begin
        ent_we = pend_q;
        ent_wd = tmp_rd_q;
        if (idx_lt_cnt) begin
          tmp_re = 1'b1;
          wa_d   = idx_q[AW-1:0];
          pend_d = 1'b1;
          idx_d  = CW'(idx_inc);
        end else begin
          pend_d = 1'b0;
        end
      end
      ale_pkg::S_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ale_pkg::S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= ale_pkg::action_e'(in_item_i.action);
      value_q <= in_item_i.value;
      key_q   <= in_item_i.key;
      pos_q   <= in_item_i.position;
      off_q   <= in_item_i.offset;
    end
    status_q <= status_d;
    word_q   <= word_d;
    fidx_q   <= fidx_d;
    idx_q    <= idx_d;
    p_q      <= p_d;
    j_q      <= j_d;
    wa_q     <= wa_d;
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_rd_q <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tmp_we) tmp_mem[tmp_wa] <= ent_rd_q;
    if (tmp_re) tmp_rd_q <= tmp_mem[tmp_ra];
  end

endmodule

@@ sim/array_list_engine_tb.sv @@
// Testbench for the array list engine: directed table, random actions, shadow-list checking.
module array_list_engine_tb;

  localparam int unsigned ActW     = ale_pkg::ActW;
  localparam int unsigned WordW    = ale_pkg::WordW;
  localparam int unsigned PosW     = ale_pkg::PosW;
  localparam int unsigned OffW     = ale_pkg::OffW;
  localparam int unsigned StatW    = ale_pkg::StatW;
  localparam int unsigned FidxW    = ale_pkg::FidxW;
  localparam int unsigned LenW     = ale_pkg::LenW;
  localparam int unsigned InDataW  = ale_pkg::InDataW;
  localparam int unsigned OutDataW = ale_pkg::OutDataW;

  localparam int unsigned CAP = ale_pkg::DefCapacity;
  localparam int unsigned RANDOM_PER_PHASE = 68;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_CYCLES = 2 * CAP + 24;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam logic [ActW-1:0] ACT_UNDEF_LO = 4'd9;
  localparam logic [ActW-1:0] ACT_UNDEF_HI = 4'd15;

  typedef struct packed {
    logic [ActW-1:0]  act;
    logic [WordW-1:0] val;
    logic [WordW-1:0] key;
    logic [PosW-1:0]  pos;
    logic [OffW-1:0]  off;
    logic             typed;
    logic [StatW-1:0] st;
    logic [FidxW-1:0] idx;
    logic [LenW-1:0]  len;
  } stim_row_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [WordW-1:0] word;
    logic [FidxW-1:0] idx;
    logic [LenW-1:0]  len;
    logic             last;
  } list_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  logic [WordW-1:0] shadow_words [CAP];
  int unsigned      shadow_len;
  list_result_t     expected_results [$];
  int unsigned      mismatches = 0;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  logic             long_hold_pending = 1'b0;

  array_list_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  task automatic apply_to_shadow_list(input logic [ActW-1:0] act, input logic [WordW-1:0] val,
                                      input logic [WordW-1:0] key, input logic [PosW-1:0] pos,
                                      input logic [OffW-1:0] off);
    logic [StatW-1:0] st;
    logic [WordW-1:0] w;
    logic [FidxW-1:0] idx;
    logic [WordW-1:0] rotated [CAP];
    int unsigned p;
    int unsigned sh;
    int i;
    st = ale_pkg::ST_OK;
    w = '0;
    idx = '0;
    case (act)
      ale_pkg::ACT_INS_FRONT, ale_pkg::ACT_INS_BACK, ale_pkg::ACT_INS_AT: begin
        p = (act == ale_pkg::ACT_INS_FRONT) ? 0 :
            (act == ale_pkg::ACT_INS_BACK) ? shadow_len : pos;
        if (p > shadow_len) begin
          st = ale_pkg::ST_BADPOS;
        end else if (shadow_len >= CAP) begin
          st = ale_pkg::ST_FULL;
        end else begin
          for (i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = val;
          shadow_len++;
        end
      end
      ale_pkg::ACT_DEL_FRONT, ale_pkg::ACT_DEL_BACK, ale_pkg::ACT_DEL_AT: begin
        p = (act == ale_pkg::ACT_DEL_FRONT) ? 0 :
            (act == ale_pkg::ACT_DEL_BACK) ? ((shadow_len == 0) ? 0 : shadow_len - 1) : pos;
        if (shadow_len == 0) begin
          st = ale_pkg::ST_EMPTY;
        end else if (p >= shadow_len) begin
          st = ale_pkg::ST_BADPOS;
        end else begin
          w = shadow_words[p];
          for (i = p; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      ale_pkg::ACT_SEARCH: begin
        st = ale_pkg::ST_NOTFOUND;
        for (i = 0; i < shadow_len; i++) begin
          if (st == ale_pkg::ST_NOTFOUND && shadow_words[i] == key) begin
            st = ale_pkg::ST_OK;
            idx = FidxW'(i);
          end
        end
      end
      ale_pkg::ACT_LIST_ALL: begin
        if (shadow_len == 0) begin
          st = ale_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i < shadow_len; i++) begin
            expected_results.push_back({StatW'(ale_pkg::ST_OK), shadow_words[i], 3'd0,
                                        LenW'(shadow_len), i + 1 == shadow_len});
          end
          return;
        end
      end
      ale_pkg::ACT_ROTATE: begin
        if (shadow_len == 0) begin
          st = ale_pkg::ST_EMPTY;
        end else begin
          sh = off % shadow_len;
          for (i = 0; i < shadow_len; i++) rotated[(i + sh) % shadow_len] = shadow_words[i];
          for (i = 0; i < shadow_len; i++) shadow_words[i] = rotated[i];
        end
      end
      default: begin
      end
    endcase
    expected_results.push_back({st, w, idx, LenW'(shadow_len), 1'b1});
  endtask

  function automatic stim_row_t stim(input logic [ActW-1:0] act, input logic [WordW-1:0] val,
                                     input logic [WordW-1:0] key, input int unsigned pos,
                                     input int unsigned off, input int unsigned typed,
                                     input logic [StatW-1:0] st, input int unsigned idx,
                                     input int unsigned len);
    stim_row_t r;
    r.act   = act;
    r.val   = val;
    r.key   = key;
    r.pos   = PosW'(pos);
    r.off   = OffW'(off);
    r.typed = (typed != 0);
    r.st    = st;
    r.idx   = FidxW'(idx);
    r.len   = LenW'(len);
    return r;
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    logic [WordW-1:0] w;
    case ($urandom_range(3))
      0: w = $urandom;
      1: w = $urandom_range(7) - 4;
      2: begin
        case ($urandom_range(3))
          0: w = 32'h8000_0000;
          1: w = 32'h7fff_ffff;
          2: w = 32'h0000_0000;
          default: w = 32'hffff_ffff;
        endcase
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int unsigned pick;
    r = '0;
    pick = $urandom_range(99);
    if (shadow_len >= CAP - 1 && $urandom_range(1) == 1) pick = 40 + $urandom_range(24);
    if (pick < 14) r.act = ale_pkg::ACT_INS_FRONT;
    else if (pick < 28) r.act = ale_pkg::ACT_INS_BACK;
    else if (pick < 40) r.act = ale_pkg::ACT_INS_AT;
    else if (pick < 48) r.act = ale_pkg::ACT_DEL_FRONT;
    else if (pick < 55) r.act = ale_pkg::ACT_DEL_BACK;
    else if (pick < 65) r.act = ale_pkg::ACT_DEL_AT;
    else if (pick < 77) r.act = ale_pkg::ACT_SEARCH;
    else if (pick < 85) r.act = ale_pkg::ACT_LIST_ALL;
    else if (pick < 95) r.act = ale_pkg::ACT_ROTATE;
    else r.act = ActW'($urandom_range(ACT_UNDEF_HI, ACT_UNDEF_LO));
    r.val = pick_word();
    if (shadow_len > 0 && $urandom_range(9) < 6) begin
      r.key = shadow_words[$urandom_range(shadow_len - 1)];
    end else begin
      r.key = pick_word();
    end
    if ($urandom_range(4) == 0) r.pos = PosW'($urandom_range(15));
    else r.pos = PosW'($urandom_range(shadow_len));
    r.off = OffW'($urandom);
    return r;
  endfunction

  task automatic send_item(input stim_row_t r);
    list_result_t typed_res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.off, r.pos, r.key, r.val, r.act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_to_shadow_list(r.act, r.val, r.key, r.pos, r.off);
    if (r.typed) begin
      void'(expected_results.pop_back());
      typed_res = {r.st, 32'd0, r.idx, r.len, 1'b1};
      expected_results.push_back(typed_res);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned snd, input int unsigned rcv, input logic hold);
    @(posedge clk_i);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    long_hold_pending = hold;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned held;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          m_axis_tready <= 1'b0;
          held++;
          @(negedge clk_i);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[37:35],
             m_axis_tdata[41:38], m_axis_tlast};
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", got.word, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          report_mismatch("status", 32'(got.status), 32'(want.status));
        end
        if (got.word !== want.word) report_mismatch("word", got.word, want.word);
        if (got.idx !== want.idx) begin
          report_mismatch("found_index", 32'(got.idx), 32'(want.idx));
        end
        if (got.len !== want.len) report_mismatch("length", 32'(got.len), 32'(want.len));
        if (got.last !== want.last) begin
          report_mismatch("last", 32'(got.last), 32'(want.last));
        end
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    int unsigned n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    send_idle_pct = 20;
    recv_idle_pct = 53;
    shadow_len    = 0;
    for (n = 0; n < CAP; n++) shadow_words[n] = '0;

    // Empty-list behavior first, then the fill to capacity and the full-store cases.
    rows.push_back(stim(ale_pkg::ACT_LIST_ALL,  '0,           '0,           0,  0,   1,
                        ale_pkg::ST_EMPTY,    0, 0));
    rows.push_back(stim(ale_pkg::ACT_DEL_FRONT, '0,           '0,           0,  0,   1,
                        ale_pkg::ST_EMPTY,    0, 0));
    rows.push_back(stim(ale_pkg::ACT_DEL_BACK,  '0,           '0,           0,  0,   1,
                        ale_pkg::ST_EMPTY,    0, 0));
    rows.push_back(stim(ale_pkg::ACT_DEL_AT,    '0,           '0,           15, 0,   1,
                        ale_pkg::ST_EMPTY,    0, 0));
    rows.push_back(stim(ale_pkg::ACT_ROTATE,    '0,           '0,           0,  255, 1,
                        ale_pkg::ST_EMPTY,    0, 0));
    rows.push_back(stim(ale_pkg::ACT_SEARCH,    '0,           '0,           0,  0,   1,
                        ale_pkg::ST_NOTFOUND, 0, 0));
    rows.push_back(stim(ale_pkg::ACT_INS_AT,    32'd5,        '0,           1,  0,   1,
                        ale_pkg::ST_BADPOS,   0, 0));
    rows.push_back(stim(ale_pkg::ACT_INS_FRONT, 32'h7fffffff, '0,           0,  0,   1,
                        ale_pkg::ST_OK,       0, 1));
    rows.push_back(stim(ale_pkg::ACT_ROTATE,    '0,           '0,           0,  255, 1,
                        ale_pkg::ST_OK,       0, 1));
    rows.push_back(stim(ale_pkg::ACT_INS_BACK,  32'h80000000, '0,           0,  0,   1,
                        ale_pkg::ST_OK,       0, 2));
    rows.push_back(stim(ale_pkg::ACT_INS_AT,    32'hffffffff, '0,           1,  0,   1,
                        ale_pkg::ST_OK,       0, 3));
    rows.push_back(stim(ale_pkg::ACT_DEL_AT,    '0,           '0,           3,  0,   1,
                        ale_pkg::ST_BADPOS,   0, 3));
    rows.push_back(stim(ale_pkg::ACT_SEARCH,    '0,           32'hffffffff, 0,  0,   1,
                        ale_pkg::ST_OK,       1, 3));
    rows.push_back(stim(ACT_UNDEF_LO,           '0,           '0,           0,  0,   1,
                        ale_pkg::ST_OK,       0, 3));
    rows.push_back(stim(ACT_UNDEF_HI,           '1,           '1,           15, 255, 1,
                        ale_pkg::ST_OK,       0, 3));
    rows.push_back(stim(ale_pkg::ACT_INS_BACK,  32'd1,        '0,           0,  0,   0,
                        ale_pkg::ST_OK,       0, 0));
    rows.push_back(stim(ale_pkg::ACT_INS_AT,    32'd2,        '0,           2,  0,   0,
                        ale_pkg::ST_OK,       0, 0));
    rows.push_back(stim(ale_pkg::ACT_INS_FRONT, 32'd3,        '0,           0,  0,   0,
                        ale_pkg::ST_OK,       0, 0));
    rows.push_back(stim(ale_pkg::ACT_INS_AT,    32'd4,        '0,           6,  0,   0,
                        ale_pkg::ST_OK,       0, 0));
    rows.push_back(stim(ale_pkg::ACT_INS_BACK,  32'd5,        '0,           0,  0,   0,
                        ale_pkg::ST_OK,       0, 0));
    rows.push_back(stim(ale_pkg::ACT_INS_FRONT, 32'd6,        '0,           0,  0,   1,
                        ale_pkg::ST_FULL,     0, 8));
    rows.push_back(stim(ale_pkg::ACT_INS_AT,    32'd7,        '0,           9,  0,   1,
                        ale_pkg::ST_BADPOS,   0, 8));
    rows.push_back(stim(ale_pkg::ACT_INS_AT,    32'd8,        '0,           8,  0,   1,
                        ale_pkg::ST_FULL,     0, 8));
    rows.push_back(stim(ale_pkg::ACT_LIST_ALL,  '0,           '0,           0,  0,   0,
                        ale_pkg::ST_OK,       0, 0));
    rows.push_back(stim(ale_pkg::ACT_ROTATE,    '0,           '0,           0,  255, 0,
                        ale_pkg::ST_OK,       0, 0));
    rows.push_back(stim(ale_pkg::ACT_LIST_ALL,  '0,           '0,           0,  0,   0,
                        ale_pkg::ST_OK,       0, 0));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (rows[i]) send_item(rows[i]);
    for (n = 0; n < RANDOM_PER_PHASE; n++) send_item(random_row());
    wait_drained();

    set_idling(53, 20, 1'b0);
    for (n = 0; n < RANDOM_PER_PHASE; n++) send_item(random_row());
    wait_drained();

    // The receiver stalls for a long stretch while items keep coming.
    set_idling(0, 0, 1'b1);
    for (n = 0; n < RANDOM_PER_PHASE; n++) send_item(random_row());
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ale_pkg.sv
hw/rtl/ale_mod.sv
hw/rtl/ale_ctrl.sv
hw/rtl/array_list_engine.sv
sim/array_list_engine_tb.sv
